### hw/rtl/spvds_pkg.sv
package spvds_pkg;

    localparam int MAX_SPLATS_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_SORT  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Z   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_OFF = 3'd3;

    localparam logic signed [31:0] VIEW_Z_RESET = 32'sd65536;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_SORT  = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_job;

    typedef struct packed {
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
        logic signed [31:0] off;
    } t_view;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_queue_head;

endpackage

### hw/rtl/splat_view_depth_sort_top.sv
// splat view-depth sort
// input channel (i_valid/o_ready): i_func selects load (append one position to
// the store, numbered in load order), sort, or clear; other codes are dropped.
// output channel (o_valid/i_ready): one transfer per stored splat after a sort,
// ascending view depth, equal depths by lower index, o_last_of_run on the last.
// config: i_cfg_we writes view row x, y, z, offset at index 0..3.
// a two-entry command queue sits between the intake and the sort engine, so a
// load or clear is taken while the queue has room, and items keep queuing
// during a sort. a sort first computes each splat's depth through a three-stage
// read/multiply/sum pipe, then for each output makes a pass over the depth memory,
// picking the next key above the previous one.
// the output register holds a result until taken; a stalled receiver halts the
// sort engine while the queue keeps accepting until it fills.
// synchronous reset empties the store and queue and restores the view row.
module splat_view_depth_sort_top #(
    parameter int MAX_SPLATS = spvds_pkg::MAX_SPLATS_DEF,
    parameter int FRAC_BITS  = spvds_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_func,
    input  logic signed [31:0]                i_pos_x,
    input  logic signed [31:0]                i_pos_y,
    input  logic signed [31:0]                i_pos_z,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [$clog2(MAX_SPLATS)-1:0]     o_splat_index,
    output logic signed [31:0]                o_view_depth,
    output logic                              o_last_of_run,
    input  logic                              i_cfg_we,
    input  logic [spvds_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [31:0]                       i_cfg_data
);

    spvds_pkg::t_view       view;
    spvds_pkg::t_queue_head head;
    logic                   pop;

    spvds_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_func     (i_func),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_view     (view),
        .o_head     (head),
        .i_pop      (pop)
    );

    spvds_back #(
        .MAX_SPLATS (MAX_SPLATS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_view        (view),
        .i_head        (head),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_splat_index (o_splat_index),
        .o_view_depth  (o_view_depth),
        .o_last_of_run (o_last_of_run)
    );

endmodule

### hw/rtl/spvds_front.sv
module spvds_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_func,
    input  logic signed [31:0]                   i_pos_x,
    input  logic signed [31:0]                   i_pos_y,
    input  logic signed [31:0]                   i_pos_z,
    input  logic                                 i_cfg_we,
    input  logic [spvds_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [31:0]                          i_cfg_data,
    output spvds_pkg::t_view                     o_view,
    output spvds_pkg::t_queue_head               o_head,
    input  logic                                 i_pop
);

    localparam int QDepth = 2;

    spvds_pkg::t_job r_q [QDepth];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_qcnt;
    spvds_pkg::t_view r_view;

    spvds_pkg::t_job dec_job;
    logic            dec_keep;
    logic            push;
    logic            pop;

    // classify: no-op codes never reach the queue
    always_comb begin
        dec_job.x   = i_pos_x;
        dec_job.y   = i_pos_y;
        dec_job.z   = i_pos_z;
        dec_keep    = 1'b1;
        dec_job.cmd = spvds_pkg::CMD_LOAD;
        unique case (i_func)
            spvds_pkg::FUNC_LOAD:  dec_job.cmd = spvds_pkg::CMD_LOAD;
            spvds_pkg::FUNC_SORT:  dec_job.cmd = spvds_pkg::CMD_SORT;
            spvds_pkg::FUNC_CLEAR: dec_job.cmd = spvds_pkg::CMD_CLEAR;
            default:               dec_keep    = 1'b0;
        endcase
    end

    assign o_ready = (r_qcnt != 2'(QDepth));
    assign push    = i_valid && o_ready && dec_keep;
    assign pop     = i_pop && (r_qcnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_qcnt <= 2'd0;
            r_view.wx  <= '0;
            r_view.wy  <= '0;
            r_view.wz  <= spvds_pkg::VIEW_Z_RESET;
            r_view.off <= '0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            if (push && !pop)      r_qcnt <= r_qcnt + 2'd1;
            else if (pop && !push) r_qcnt <= r_qcnt - 2'd1;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    spvds_pkg::CFG_VIEW_X:   r_view.wx  <= i_cfg_data;
                    spvds_pkg::CFG_VIEW_Y:   r_view.wy  <= i_cfg_data;
                    spvds_pkg::CFG_VIEW_Z:   r_view.wz  <= i_cfg_data;
                    spvds_pkg::CFG_VIEW_OFF: r_view.off <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= dec_job;
    end

    assign o_view       = r_view;
    assign o_head.valid = (r_qcnt != 2'd0);
    assign o_head.job   = r_q[r_rp];

    a_qcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= 2'(QDepth))
        else $error("queue count overflow");

endmodule

### hw/rtl/spvds_back.sv
module spvds_back #(
    parameter int MAX_SPLATS = spvds_pkg::MAX_SPLATS_DEF,
    parameter int FRAC_BITS  = spvds_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  spvds_pkg::t_view                  i_view,
    input  spvds_pkg::t_queue_head            i_head,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [$clog2(MAX_SPLATS)-1:0]     o_splat_index,
    output logic signed [31:0]                o_view_depth,
    output logic                              o_last_of_run
);

    localparam int IdxW = $clog2(MAX_SPLATS);
    localparam int CntW = $clog2(MAX_SPLATS + 1);
    localparam int SumW = 66;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DEPTH = 4'b0010,
        S_SCAN  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state;

    logic signed [31:0] mem_x   [MAX_SPLATS];
    logic signed [31:0] mem_y   [MAX_SPLATS];
    logic signed [31:0] mem_z   [MAX_SPLATS];
    logic signed [31:0] mem_key [MAX_SPLATS];

    logic [CntW-1:0] r_count;
    logic [CntW-1:0] r_addr;
    logic [CntW-1:0] r_emit_cnt;
    logic            r_v1, r_v2, r_kv;
    logic [IdxW-1:0] r_i1, r_i2, r_kj;
    logic signed [31:0] r_rx, r_ry, r_rz;
    logic signed [63:0] r_px, r_py, r_pz;
    logic signed [31:0] r_key_rd;
    logic            r_best_v, r_have_last, r_ov;
    logic signed [31:0] r_best_d, r_last_d;
    logic [IdxW-1:0] r_best_i, r_last_i;

    logic               issue, load_we, cand, better, emit_go, last_emit;
    logic signed [SumW-1:0] sum, shifted;
    logic signed [31:0] depth_sat;

    assign issue     = (r_addr < r_count);
    assign o_pop     = (r_state == S_IDLE) && i_head.valid;
    assign load_we   = o_pop && (i_head.job.cmd == spvds_pkg::CMD_LOAD)
                       && (r_count < CntW'(MAX_SPLATS));
    assign emit_go   = (r_state == S_EMIT) && (!r_ov || i_ready);
    assign last_emit = (r_emit_cnt == CntW'(r_count - 1'b1));

    // exact sum at twice the fraction bits, floor, then clamp
    always_comb begin
        sum = SumW'(r_px) + SumW'(r_py) + SumW'(r_pz)
            + (SumW'(i_view.off) <<< FRAC_BITS);
        shifted = sum >>> FRAC_BITS;
        if (shifted > SumW'(64'sh7FFFFFFF))
            depth_sat = 32'sh7FFFFFFF;
        else if (shifted < -SumW'(64'sh80000000))
            depth_sat = -32'sh7FFFFFFF - 32'sd1;
        else
            depth_sat = shifted[31:0];
    end

    // next after the previous emission, ties to the lower index
    assign cand   = r_kv && (!r_have_last || (r_key_rd > r_last_d)
                    || ((r_key_rd == r_last_d) && (r_kj > r_last_i)));
    assign better = cand && (!r_best_v || (r_key_rd < r_best_d));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_addr      <= '0;
            r_emit_cnt  <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_kv        <= 1'b0;
            r_best_v    <= 1'b0;
            r_have_last <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_DEPTH) && issue;
            r_v2 <= r_v1;
            r_kv <= (r_state == S_SCAN) && issue;
            if (emit_go)      r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_head.job.cmd)
                            spvds_pkg::CMD_LOAD: begin
                                if (load_we) r_count <= r_count + 1'b1;
                            end
                            spvds_pkg::CMD_CLEAR: r_count <= '0;
                            spvds_pkg::CMD_SORT: begin
                                if (r_count != '0) begin
                                    r_state <= S_DEPTH;
                                    r_addr  <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DEPTH: begin
                    if (issue) r_addr <= r_addr + 1'b1;
                    else if (!r_v1 && !r_v2) begin
                        r_state     <= S_SCAN;
                        r_addr      <= '0;
                        r_best_v    <= 1'b0;
                        r_have_last <= 1'b0;
                        r_emit_cnt  <= '0;
                    end
                end
                S_SCAN: begin
                    if (issue) r_addr <= r_addr + 1'b1;
                    if (better) r_best_v <= 1'b1;
                    if (!issue && !r_kv) r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit_go) begin
                        r_have_last <= 1'b1;
                        if (last_emit) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_emit_cnt <= r_emit_cnt + 1'b1;
                            r_state    <= S_SCAN;
                            r_addr     <= '0;
                            r_best_v   <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            mem_x[r_count[IdxW-1:0]] <= i_head.job.x;
            mem_y[r_count[IdxW-1:0]] <= i_head.job.y;
            mem_z[r_count[IdxW-1:0]] <= i_head.job.z;
        end
        r_rx <= mem_x[r_addr[IdxW-1:0]];
        r_ry <= mem_y[r_addr[IdxW-1:0]];
        r_rz <= mem_z[r_addr[IdxW-1:0]];
        if (r_v2) mem_key[r_i2] <= depth_sat;
        r_key_rd <= mem_key[r_addr[IdxW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_i1 <= r_addr[IdxW-1:0];
        r_i2 <= r_i1;
        r_kj <= r_addr[IdxW-1:0];
        r_px <= r_rx * i_view.wx;
        r_py <= r_ry * i_view.wy;
        r_pz <= r_rz * i_view.wz;
        if (better) begin
            r_best_d <= r_key_rd;
            r_best_i <= r_kj;
        end
        if (emit_go) begin
            r_last_d      <= r_best_d;
            r_last_i      <= r_best_i;
            o_splat_index <= r_best_i;
            o_view_depth  <= r_best_d;
            o_last_of_run <= last_emit;
        end
    end

    assign o_valid = r_ov;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MAX_SPLATS))
        else $error("splat count above store size");

    a_emit_has_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_best_v)
        else $error("emit without a selected splat");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_go && last_emit) |=> ((r_state == S_IDLE) && o_valid && o_last_of_run))
        else $error("final transfer did not end the run");

    a_emit_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) || (r_state == S_EMIT)) |-> (r_emit_cnt < r_count))
        else $error("emission count past store fill");

endmodule

### dv/splat_view_depth_sort_top_tb.sv
module splat_view_depth_sort_top_tb;
    import spvds_pkg::*;

    localparam int NSPLAT = 64;
    localparam int CYCLE_LIMIT = 10000000;
    localparam logic [1:0] FUNC_NOP = 2'd3;

    typedef struct {
        logic [5:0]         idx;
        logic signed [31:0] depth;
        logic               last;
    } t_sorted;

    class depth_order_board;
        int wx, wy, wz, woff;
        int px[NSPLAT], py[NSPLAT], pz[NSPLAT];
        int count;
        t_sorted order_q[$];
        int errors;

        function new();
            wx = 0; wy = 0; wz = 65536; woff = 0;
            count = 0; errors = 0;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            errors++;
        endtask

        function void set_view(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
            case (idx)
                CFG_VIEW_X:   wx = v;
                CFG_VIEW_Y:   wy = v;
                CFG_VIEW_Z:   wz = v;
                CFG_VIEW_OFF: woff = v;
                default: ;
            endcase
        endfunction

        function logic signed [31:0] view_depth(int i);
            logic signed [79:0] acc;
            longint p;
            p = longint'(wx) * longint'(px[i]);
            acc = p;
            p = longint'(wy) * longint'(py[i]);
            acc = acc + p;
            p = longint'(wz) * longint'(pz[i]);
            acc = acc + p;
            p = longint'(woff) <<< 16;
            acc = acc + p;
            acc = acc >>> 16;
            if (acc > 80'sd2147483647) return 32'sh7fffffff;
            if (acc < -80'sd2147483648) return 32'sh80000000;
            return acc[31:0];
        endfunction

        function void note_input(logic [1:0] f, int x, int y, int z);
            int keys[NSPLAT];
            int ord[NSPLAT];
            int cur, j;
            t_sorted e;
            if (f == FUNC_LOAD) begin
                if (count < NSPLAT) begin
                    px[count] = x; py[count] = y; pz[count] = z;
                    count++;
                end
            end else if (f == FUNC_CLEAR) begin
                count = 0;
            end else if (f == FUNC_SORT) begin
                for (int i = 0; i < count; i++) begin
                    keys[i] = view_depth(i);
                    ord[i] = i;
                end
                // insertion sort, equal depths keep lower index first
                for (int i = 1; i < count; i++) begin
                    cur = ord[i];
                    j = i;
                    while (j > 0 && keys[cur] < keys[ord[j-1]]) begin
                        ord[j] = ord[j-1];
                        j--;
                    end
                    ord[j] = cur;
                end
                for (int i = 0; i < count; i++) begin
                    e.idx = ord[i];
                    e.depth = keys[ord[i]];
                    e.last = (i == count - 1);
                    order_q.insert(order_q.size(), e);
                end
            end
        endfunction

        task check(logic [5:0] idx, logic signed [31:0] depth, logic last);
            t_sorted e;
            if (order_q.size() == 0) begin
                report($sformatf("unexpected result idx %0d", idx));
                return;
            end
            e = order_q.pop_front();
            if (idx !== e.idx)
                report($sformatf("splat_index %0d, want %0d", idx, e.idx));
            if (depth !== e.depth)
                report($sformatf("view_depth %0d, want %0d", depth, e.depth));
            if (last !== e.last)
                report($sformatf("last_of_run %0b, want %0b", last, e.last));
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_func;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic               o_valid;
    logic               i_ready;
    logic [5:0]         o_splat_index;
    logic signed [31:0] o_view_depth;
    logic               o_last_of_run;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [31:0]        i_cfg_data;

    splat_view_depth_sort_top uut (.*);

    depth_order_board board = new();
    int cycles = 0;
    int stall_left = 0;
    bit rx_busy_free = 0;
    int items_sent = 0;

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        i_valid = 0;
        i_func = FUNC_NOP;
        i_pos_x = 0; i_pos_y = 0; i_pos_z = 0;
        i_ready = 0;
        i_cfg_we = 0;
        i_cfg_idx = CFG_VIEW_X;
        i_cfg_data = 0;
    end

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver: random stall before each result transfer, none while rx_busy_free is set
    always @(posedge i_clk) begin
        int nxt;
        if (!i_rst_n) begin
            i_ready <= 0;
            stall_left <= 0;
        end else if (o_valid && i_ready) begin
            board.check(o_splat_index, o_view_depth, o_last_of_run);
            nxt = rx_busy_free ? 0 : $urandom_range(0, 7);
            stall_left <= nxt;
            i_ready <= (nxt == 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= (stall_left == 1);
        end else begin
            i_ready <= 1;
        end
    end

    task send(logic [1:0] f, int x, int y, int z, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_func <= f;
        i_pos_x <= x; i_pos_y <= y; i_pos_z <= z;
        do @(posedge i_clk); while (!o_ready);
        board.note_input(f, x, y, z);
        items_sent++;
    endtask

    task wait_drained();
        i_valid <= 0;
        @(posedge i_clk);
        while (board.order_q.size() != 0) @(posedge i_clk);
        // a trailing load, clear or empty sort may still be in the queue
        repeat (60) @(posedge i_clk);
    endtask

    task write_view(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        board.set_view(idx, v);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    function int rand_pos();
        if ($urandom_range(0, 2) == 0) return ($urandom_range(0, 8) - 4) <<< 16;
        return $urandom;
    endfunction

    task load_and_sort(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) send(FUNC_NOP, $urandom, $urandom, $urandom);
            send(FUNC_LOAD, rand_pos(), rand_pos(), rand_pos());
        end
        send(FUNC_SORT, $urandom, $urandom, $urandom);
    endtask

    initial begin
        int n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset view row, empty sort, extremes, ties, noise
        send(FUNC_SORT, 0, 0, 0);
        send(FUNC_LOAD, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send(FUNC_LOAD, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send(FUNC_LOAD, 0, 0, 0);
        send(FUNC_LOAD, 5, 6, 0);
        send(FUNC_NOP, -1, -1, -1);
        send(FUNC_LOAD, -65536, 0, -1);
        send(FUNC_SORT, 0, 0, 0);
        wait_drained();

        // saturation both ways
        write_view(CFG_VIEW_X, 32'h7fffffff);
        write_view(CFG_VIEW_Y, 32'h80000000);
        write_view(CFG_VIEW_Z, 32'h7fffffff);
        write_view(CFG_VIEW_OFF, 32'h80000000);
        write_view(3'd5, 32'h12345678);
        send(FUNC_SORT, 0, 0, 0);
        send(FUNC_CLEAR, 0, 0, 0);
        send(FUNC_SORT, 0, 0, 0);
        send(FUNC_LOAD, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        send(FUNC_LOAD, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        send(FUNC_LOAD, 1, 1, 1);
        send(FUNC_LOAD, 1, 1, 1);
        send(FUNC_SORT, 0, 0, 0);
        wait_drained();

        // full store plus one ignored load
        write_view(CFG_VIEW_OFF, 32'h7fffffff);
        send(FUNC_CLEAR, 0, 0, 0);
        for (int i = 0; i < NSPLAT + 1; i++) send(FUNC_LOAD, rand_pos(), rand_pos(), rand_pos(), 1);
        send(FUNC_SORT, 0, 0, 0);
        wait_drained();

        for (int phase = 0; items_sent < 370; phase++) begin
            case (phase % 4)
                0: begin
                    write_view(CFG_VIEW_X, $urandom);
                    write_view(CFG_VIEW_Y, $urandom);
                    write_view(CFG_VIEW_Z, $urandom);
                    write_view(CFG_VIEW_OFF, $urandom);
                end
                1: begin
                    write_view(CFG_VIEW_X, 0);
                    write_view(CFG_VIEW_Y, 0);
                    write_view(CFG_VIEW_Z, 32'h00010000);
                    write_view(CFG_VIEW_OFF, 0);
                end
                2: begin
                    write_view(CFG_VIEW_X, ($urandom_range(0, 4) - 2) <<< 16);
                    write_view(CFG_VIEW_Y, ($urandom_range(0, 4) - 2) <<< 16);
                    write_view(CFG_VIEW_Z, $urandom);
                    write_view(CFG_VIEW_OFF, 32'h80000000);
                end
                default: begin
                    write_view(CFG_VIEW_X, 32'h80000000);
                    write_view(CFG_VIEW_Z, 32'h7fffffff);
                end
            endcase
            rx_busy_free = (phase % 3 == 2);
            for (int s = 0; s < 6 && items_sent < 370; s++) begin
                if ($urandom_range(0, 2) == 0) send(FUNC_CLEAR, $urandom, $urandom, $urandom);
                n = ($urandom_range(0, 24) == 0) ? $urandom_range(30, 64) : $urandom_range(0, 9);
                load_and_sort(n);
                // hold off until the board has caught up
                if (phase == 1 && s == 2) wait_drained();
            end
            wait_drained();
        end
        rx_busy_free = 0;

        wait_drained();
        if (board.errors == 0 && board.order_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
